[rtl/core/kmd_pkg.sv]
// ----------------------------------------------------------------------------
// kmd_pkg: key matrix debouncer shared definitions
// Matrix geometry, field widths, per-key state entry and key numbering.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 16;
    localparam int KEY_COUNT    = ROW_COUNT * COLUMN_COUNT;
    localparam int KEY_W        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int TICK_W    = 8;
    localparam int KEY_NUM_W = 7;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic [TICK_W-1:0] BOUNCE_RESET = TICK_W'(5);

    typedef struct packed {
        logic              raw;
        logic              rep;
        logic [TICK_W-1:0] change_time;
    } key_entry_t;

    localparam key_entry_t ENTRY_RESET = '{raw: 1'b0, rep: 1'b0, change_time: '0};

    function automatic logic key_in_range(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] column);
        return (int'(row) < ROW_COUNT) && (int'(column) < COLUMN_COUNT);
    endfunction

    function automatic logic [KEY_W-1:0] key_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] column);
        return KEY_W'(int'(row) * COLUMN_COUNT + int'(column));
    endfunction

endpackage

[rtl/core/key_matrix_debouncer_top.sv]
// ----------------------------------------------------------------------------
// key_matrix_debouncer_top: scanned key matrix debouncer
// Per-key raw level, reported level and change tick; emits press and release
// events once a new raw level has held longer than bounce_ticks.
//
//   channel  dir  payload (low bit up)
//   s_*      in   row[2:0] column[6:3] closed[7] now_tick[15:8]
//   m_*      out  key_number[6:0] pressed[7]
//   cfg_*    in   bounce_ticks[7:0], written when cfg_wen is high
//
// One sample per cycle unless an event waits on a full output register.
// Stages: input register, key state RAM read, update/write with event output.
// Back-to-back samples on the same key are resolved by forwarding the last write.
// Reset clears the per-key valid bits at once, so all keys read as open.
// m_tready low holds an event in the output register; samples without an event
// keep flowing until an event meets a full output register.
// ----------------------------------------------------------------------------
module key_matrix_debouncer_top
    import kmd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // row, column, closed, now_tick
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // key_number, pressed
    input  logic                cfg_wen,
    input  logic [TICK_W-1:0]   cfg_wdata  // bounce_ticks
);

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_column;
    logic              in_closed;
    logic [TICK_W-1:0] in_now;
    logic              s_fire;

    logic [TICK_W-1:0] bounce_ticks_reg;

    logic              s1_valid_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic              s1_closed_reg;
    logic [TICK_W-1:0] s1_now_reg;

    logic              s2_valid_reg;
    logic [KEY_W-1:0]  s2_key_reg;
    logic              s2_closed_reg;
    logic [TICK_W-1:0] s2_now_reg;
    key_entry_t        rd_entry_reg;
    logic              rd_vld_reg;

    key_entry_t        key_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] key_vld_reg;

    logic              fwd_vld_reg;
    logic [KEY_W-1:0]  fwd_key_reg;
    key_entry_t        fwd_entry_reg;

    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    key_entry_t        cur_entry;
    key_entry_t        new_entry;
    logic [TICK_W-1:0] held;
    logic              ev2;
    logic              out_free;
    logic              s2_go;
    logic              s2_accept;
    logic              s1_go;
    logic              wr_en;

    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_column = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_closed = s_tdata[ROW_W+COL_W];
    assign in_now    = s_tdata[ROW_W+COL_W+1+:TICK_W];

    always_comb begin
        if (rd_vld_reg) begin
            cur_entry = rd_entry_reg;
        end else begin
            cur_entry = ENTRY_RESET;
        end
        if (fwd_vld_reg && (fwd_key_reg == s2_key_reg)) begin
            cur_entry = fwd_entry_reg;
        end
        held      = s2_now_reg - cur_entry.change_time;
        new_entry = cur_entry;
        ev2       = 1'b0;
        if (s2_closed_reg != cur_entry.raw) begin
            new_entry.raw         = s2_closed_reg;
            new_entry.change_time = s2_now_reg;
        end else if ((cur_entry.raw != cur_entry.rep) && (held > bounce_ticks_reg)) begin
            new_entry.rep = cur_entry.raw;
            ev2           = s2_valid_reg;
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign s2_go     = s2_valid_reg && (!ev2 || out_free);
    assign s2_accept = !s2_valid_reg || s2_go;
    assign s1_go     = s1_valid_reg && s2_accept;
    assign s_tready  = !s1_valid_reg || s2_accept;
    assign s_fire    = s_tvalid && s_tready;
    assign wr_en     = s2_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounce_ticks_reg <= BOUNCE_RESET;
        end else if (cfg_wen) begin
            bounce_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_vld_reg  <= 1'b0;
            key_vld_reg  <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_fire && key_in_range(in_row, in_column);
            end
            if (s2_accept) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free) begin
                m_valid_reg <= ev2 && s2_go;
            end
            if (wr_en) begin
                fwd_vld_reg             <= 1'b1;
                key_vld_reg[s2_key_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_key_reg    <= key_of(in_row, in_column);
            s1_closed_reg <= in_closed;
            s1_now_reg    <= in_now;
        end
        if (s1_go) begin
            s2_key_reg    <= s1_key_reg;
            s2_closed_reg <= s1_closed_reg;
            s2_now_reg    <= s1_now_reg;
            rd_entry_reg  <= key_mem[s1_key_reg];
            rd_vld_reg    <= key_vld_reg[s1_key_reg];
        end
        if (wr_en) begin
            key_mem[s2_key_reg] <= new_entry;
            fwd_key_reg         <= s2_key_reg;
            fwd_entry_reg       <= new_entry;
        end
        if (out_free && ev2 && s2_go) begin
            m_data_reg <= {new_entry.rep, KEY_NUM_W'(s2_key_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_event_reports_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        ev2 |-> (new_entry.rep == new_entry.raw) && (cur_entry.rep != cur_entry.raw))
        else $error("event does not report the held raw level");

    a_write_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> key_vld_reg[$past(s2_key_reg)] && fwd_vld_reg
                  && (fwd_key_reg == $past(s2_key_reg)))
        else $error("key state write not recorded");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s2_valid_reg && m_valid_reg)
        else $error("input stalled with room in the pipeline");

    a_event_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev2 && s2_go) |=> m_valid_reg)
        else $error("event lost before output register");

endmodule
